[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/ndvi_pkg.sv]
// ---------------------------------------------------------------------------
// ndvi_pkg
// Types, widths and constants shared by the NDVI colorizer pipeline.
// ---------------------------------------------------------------------------
package ndvi_pkg;

  localparam int PX_W   = 8;
  localparam int GAIN_W = 24;
  localparam int OFFS_W = 25;
  localparam int CFG_W  = 25;
  localparam int REFL_W = 34;            // gain * pixel + offset, signed
  localparam int SUM_W  = REFL_W + 1;    // sum and difference, signed
  localparam int MAG_W  = 34;            // magnitudes of sum and difference
  localparam int REM_W  = MAG_W;         // partial remainder, below divisor unless ovf is set
  localparam int QBITS  = 22;            // quotient bits kept; larger clamps the span to its limits
  localparam int SPAN_W = QBITS + 1;     // clamped q + 1.0, range 0 .. 2^QBITS
  localparam int K_W    = 15;
  localparam int PROD_W = SPAN_W + K_W;
  localparam int CH_SHIFT = 24;
  localparam int CH_W   = PROD_W - CH_SHIFT;
  localparam int NUM_CH = 3;

  localparam int DIV_STEPS_DEF = 2;      // quotient bits resolved per divider stage

  localparam logic [SPAN_W-1:0] Q16_ONE  = SPAN_W'(65536);
  localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(1) << QBITS;
  localparam logic [PROD_W-1:0] CH_ROUND = PROD_W'(1) << (CH_SHIFT - 1);
  localparam logic [CH_W-1:0]   CH_SAT   = CH_W'(255);

  // Channel weights, 127.5 times luma weight in Q8: blue, green, red.
  localparam logic [K_W-1:0] K_TAB [NUM_CH] = '{K_W'(3721), K_W'(19160), K_W'(9759)};

  localparam logic [GAIN_W-1:0]        RED_GAIN_RST   = GAIN_W'(21703);
  localparam logic signed [OFFS_W-1:0] RED_OFFSET_RST = -25'sd196261;
  localparam logic [GAIN_W-1:0]        NIR_GAIN_RST   = GAIN_W'(48184);
  localparam logic signed [OFFS_W-1:0] NIR_OFFSET_RST = -25'sd301705;

  typedef enum logic [1:0] {
    REG_RED_GAIN   = 2'd0,
    REG_RED_OFFSET = 2'd1,
    REG_NIR_GAIN   = 2'd2,
    REG_NIR_OFFSET = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]        red_gain;
    logic signed [OFFS_W-1:0] red_offset;
    logic [GAIN_W-1:0]        nir_gain;
    logic signed [OFFS_W-1:0] nir_offset;
  } cfg_t;

  typedef struct packed {
    logic [PX_W-1:0] nir_px;
    logic [PX_W-1:0] red_px;
    logic            last;
  } pix_t;

  // Divider working set, carried stage to stage.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] dvs;
    logic [QBITS-1:0] dlo;      // dividend bits still to bring down, MSB first
    logic [QBITS-1:0] quo;
    logic             neg;
    logic             ovf;      // quotient magnitude at or above 2^QBITS
    logic             zero;     // reflectance sum was zero
    logic [PX_W-1:0]  red_px;
    logic             last;
  } div_t;

  typedef struct packed {
    logic [PX_W-1:0] blue;
    logic [PX_W-1:0] green;
    logic [PX_W-1:0] red;
    logic            zero;
    logic            last;
  } res_t;

endpackage

[src/ndvi_front.sv]
// ---------------------------------------------------------------------------
// ndvi_front
// Reflectance, sum and difference, magnitudes and divider setup (4 stages).
// ---------------------------------------------------------------------------
module ndvi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ndvi_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ndvi_pkg::pix_t      in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ndvi_pkg::div_t      out_data_o
);
  import ndvi_pkg::*;

  localparam int NST = 4;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  logic signed [REFL_W-1:0] nref_q, rref_q;
  logic [PX_W-1:0]          px1_q, px2_q, px3_q;
  logic                     last1_q, last2_q, last3_q;
  logic signed [SUM_W-1:0]  sum_q, diff_q;
  logic [MAG_W-1:0]         smag_q, dmag_q;
  logic                     neg_q, zero_q;
  div_t                     div_q;

  logic [2*GAIN_W-1-PX_W-8:0] nprod, rprod;
  logic signed [REFL_W-1:0] nref_d, rref_d;
  logic signed [SUM_W-1:0]  sum_d, diff_d, sabs, dabs;
  div_t                     div_d;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];
  assign out_data_o  = div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: gain * pixel + offset per band.
  assign nprod  = 32'(cfg_i.nir_gain) * 32'(in_data_i.nir_px);
  assign rprod  = 32'(cfg_i.red_gain) * 32'(in_data_i.red_px);
  assign nref_d = $signed({2'b00, nprod}) + REFL_W'($signed(cfg_i.nir_offset));
  assign rref_d = $signed({2'b00, rprod}) + REFL_W'($signed(cfg_i.red_offset));

  // Stage 2: sum and difference.
  assign sum_d  = SUM_W'(nref_q) + SUM_W'(rref_q);
  assign diff_d = SUM_W'(nref_q) - SUM_W'(rref_q);

  // Stage 3: magnitudes.
  assign sabs = sum_q[SUM_W-1]  ? -sum_q  : sum_q;
  assign dabs = diff_q[SUM_W-1] ? -diff_q : diff_q;

  // Stage 4: range check and first partial remainder.
  always_comb begin
    div_d        = '0;
    div_d.rem    = REM_W'(dmag_q >> 6);
    div_d.dvs    = smag_q;
    div_d.dlo    = {dmag_q[5:0], 16'h0000};
    div_d.quo    = '0;
    div_d.neg    = neg_q;
    div_d.ovf    = (dmag_q >> 6) >= smag_q;
    div_d.zero   = zero_q;
    div_d.red_px = px3_q;
    div_d.last   = last3_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      nref_q  <= nref_d;
      rref_q  <= rref_d;
      px1_q   <= in_data_i.red_px;
      last1_q <= in_data_i.last;
    end
    if (rdy[1]) begin
      sum_q   <= sum_d;
      diff_q  <= diff_d;
      px2_q   <= px1_q;
      last2_q <= last1_q;
    end
    if (rdy[2]) begin
      smag_q  <= sabs[MAG_W-1:0];
      dmag_q  <= dabs[MAG_W-1:0];
      neg_q   <= sum_q[SUM_W-1] ^ diff_q[SUM_W-1];
      zero_q  <= (sum_q == '0);
      px3_q   <= px2_q;
      last3_q <= last2_q;
    end
    if (rdy[3]) begin
      div_q <= div_d;
    end
  end

endmodule

[src/ndvi_div_stage.sv]
// ---------------------------------------------------------------------------
// ndvi_div_stage
// One registered stage of the restoring divider, NSTEPS quotient bits.
// ---------------------------------------------------------------------------
module ndvi_div_stage #(
  parameter int NSTEPS = ndvi_pkg::DIV_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ndvi_pkg::div_t      in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ndvi_pkg::div_t      out_data_o
);
  import ndvi_pkg::*;

  logic v_q;
  div_t d_q, nxt;

  assign in_ready_o  = !v_q || out_ready_i;
  assign out_valid_o = v_q;
  assign out_data_o  = d_q;

  // Bring down one dividend bit per step, subtract the divisor when it fits.
  always_comb begin
    logic [REM_W:0] t;
    logic           ge;
    nxt = in_data_i;
    for (int i = 0; i < NSTEPS; i++) begin
      t  = {nxt.rem, nxt.dlo[QBITS-1]};
      ge = (t >= {1'b0, nxt.dvs});
      nxt.dlo = nxt.dlo << 1;
      if (ge) begin
        t = t - {1'b0, nxt.dvs};
      end
      nxt.rem = t[REM_W-1:0];
      nxt.quo = {nxt.quo[QBITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) d_q <= nxt;
  end

endmodule

[src/ndvi_back.sv]
// ---------------------------------------------------------------------------
// ndvi_back
// Span clamp, channel weighting and rounding with saturation (3 stages).
// ---------------------------------------------------------------------------
module ndvi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ndvi_pkg::div_t      in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ndvi_pkg::res_t      out_data_o
);
  import ndvi_pkg::*;

  localparam int NST = 3;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  logic [SPAN_W-1:0] span_q, span_d;
  logic [PROD_W-1:0] prod_q [NUM_CH];
  logic [PX_W-1:0]   ch_q   [NUM_CH];
  logic [PX_W-1:0]   ch_d   [NUM_CH];
  logic              zero1_q, zero2_q, zero3_q;
  logic              last1_q, last2_q, last3_q;

  logic signed [SPAN_W:0] sp;
  logic [PX_W+16:0]       spz;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: span = q + 1.0 (red_px + 1.0 on a zero sum), limited to [0, 2^QBITS].
  always_comb begin
    spz = (PX_W+17)'({in_data_i.red_px, 16'h0000}) + (PX_W+17)'(Q16_ONE);
    sp  = in_data_i.neg ? $signed({1'b0, Q16_ONE}) - $signed({2'b00, in_data_i.quo})
                        : $signed({1'b0, Q16_ONE}) + $signed({2'b00, in_data_i.quo});
    if (in_data_i.zero) begin
      span_d = (spz > (PX_W+17)'(SPAN_MAX)) ? SPAN_MAX : SPAN_W'(spz);
    end else if (in_data_i.ovf) begin
      span_d = in_data_i.neg ? '0 : SPAN_MAX;
    end else if (sp[SPAN_W]) begin
      span_d = '0;
    end else if (sp > $signed({1'b0, SPAN_MAX})) begin
      span_d = SPAN_MAX;
    end else begin
      span_d = sp[SPAN_W-1:0];
    end
  end

  // Stage 3: round, drop the fraction, saturate.
  always_comb begin
    logic [PROD_W-1:0] r;
    for (int c = 0; c < NUM_CH; c++) begin
      r = (prod_q[c] + CH_ROUND) >> CH_SHIFT;
      ch_d[c] = (r[CH_W-1:0] > CH_SAT) ? PX_W'(CH_SAT) : r[PX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      span_q  <= span_d;
      zero1_q <= in_data_i.zero;
      last1_q <= in_data_i.last;
    end
    if (rdy[1]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod_q[c] <= PROD_W'(span_q) * PROD_W'(K_TAB[c]);
      end
      zero2_q <= zero1_q;
      last2_q <= last1_q;
    end
    if (rdy[2]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        ch_q[c] <= ch_d[c];
      end
      zero3_q <= zero2_q;
      last3_q <= last2_q;
    end
  end

  assign out_data_o.blue  = ch_q[0];
  assign out_data_o.green = ch_q[1];
  assign out_data_o.red   = ch_q[2];
  assign out_data_o.zero  = zero3_q;
  assign out_data_o.last  = last3_q;

endmodule

[src/ndvi_pixel_colorizer_top.sv]
// Throughput: one pixel per cycle while the output is not stalled; every stage holds on its own valid bit and
// refills as soon as the stage behind it moves, so bubbles collapse under stall.
// The pipeline depth is set by the restoring divider, DIV_STEPS quotient bits a stage.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register defaults.
// ---------------------------------------------------------------------------
// ndvi_pixel_colorizer_top
// NDVI from NIR and red pixel bytes, mapped to three luma-weighted bytes.
// ---------------------------------------------------------------------------
module ndvi_pixel_colorizer_top #(
  parameter int DIV_STEPS = ndvi_pkg::DIV_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [ndvi_pkg::CFG_W-1:0]  cfg_wdata_i,
  // pixel input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,   // [7:0] nir_pixel, [15:8] red_pixel
  input  logic                        s_axis_tlast,
  // color output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,   // [7:0] blue, [15:8] green, [23:16] red
  output logic [0:0]                  m_axis_tuser,   // [0] zero_sum
  output logic                        m_axis_tlast
);
  import ndvi_pkg::*;

  localparam int NUM_STAGES = (QBITS + DIV_STEPS - 1) / DIV_STEPS;

  cfg_t cfg_q;
  pix_t pix;
  res_t res;

  logic [NUM_STAGES:0] div_valid;
  logic [NUM_STAGES:0] div_ready;
  div_t                div_data [NUM_STAGES+1];
  logic                back_ready;

  // Register file: writes land directly, no handshake and no read path.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_gain   <= RED_GAIN_RST;
      cfg_q.red_offset <= RED_OFFSET_RST;
      cfg_q.nir_gain   <= NIR_GAIN_RST;
      cfg_q.nir_offset <= NIR_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_RED_GAIN:   cfg_q.red_gain   <= cfg_wdata_i[GAIN_W-1:0];
        REG_RED_OFFSET: cfg_q.red_offset <= $signed(cfg_wdata_i[OFFS_W-1:0]);
        REG_NIR_GAIN:   cfg_q.nir_gain   <= cfg_wdata_i[GAIN_W-1:0];
        REG_NIR_OFFSET: cfg_q.nir_offset <= $signed(cfg_wdata_i[OFFS_W-1:0]);
      endcase
    end
  end

  assign pix.nir_px = s_axis_tdata[7:0];
  assign pix.red_px = s_axis_tdata[15:8];
  assign pix.last   = s_axis_tlast;

  // Reflectances, sum, difference and divider setup.
  ndvi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (pix),
    .out_valid_o (div_valid[0]),
    .out_ready_i (div_ready[0]),
    .out_data_o  (div_data[0])
  );

  // Divider chain: quotient bits MSB first, the last stage may take fewer.
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_div
    localparam int LEFT = QBITS - k * DIV_STEPS;
    localparam int NS   = (LEFT < DIV_STEPS) ? LEFT : DIV_STEPS;
    ndvi_div_stage #(
      .NSTEPS (NS)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[k]),
      .in_ready_o  (div_ready[k]),
      .in_data_i   (div_data[k]),
      .out_valid_o (div_valid[k+1]),
      .out_ready_i (div_ready[k+1]),
      .out_data_o  (div_data[k+1])
    );
  end

  assign div_ready[NUM_STAGES] = back_ready;

  // Clamp, weight and saturate; its last stage is the output register.
  ndvi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid[NUM_STAGES]),
    .in_ready_o  (back_ready),
    .in_data_i   (div_data[NUM_STAGES]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {res.red, res.green, res.blue};
  assign m_axis_tuser = res.zero;
  assign m_axis_tlast = res.last;

endmodule

[src/ndvi_checker.sv]
// ---------------------------------------------------------------------------
// ndvi_checker
// Port-level checks on the NDVI colorizer output stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ndvi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a stalled result until it is taken.
  `ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // Pipeline comes out of reset empty.
  `ASSERT_IMPL(a_empty_after_rst, clk_i, rst_ni, !$past(rst_ni), !m_axis_tvalid)

  // Same span feeds all channels, so the weights fix their order.
  `ASSERT_IMPL(a_ch_order, clk_i, rst_ni, m_axis_tvalid,
               m_axis_tdata[15:8] >= m_axis_tdata[23:16] &&
               m_axis_tdata[23:16] >= m_axis_tdata[7:0])

  // Zero-sum fallback never maps below the index value zero.
  `ASSERT_IMPL(a_zero_floor, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0],
               m_axis_tdata[7:0] >= 8'd15)

  // Flags of a stalled result hold.
  `ASSERT_NEXT(a_hold_flags, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               $stable(m_axis_tlast) && $stable(m_axis_tuser))

endmodule

bind ndvi_pixel_colorizer_top ndvi_checker u_ndvi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
